// File: design/date_weekday_and_remaining_days_unit_defines.svh
// assertion macros shared by the checker
`ifndef DATE_WEEKDAY_AND_REMAINING_DAYS_UNIT_DEFINES_SVH
`define DATE_WEEKDAY_AND_REMAINING_DAYS_UNIT_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define DWRD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked through reset as well
`define DWRD_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/dwrd_pkg.sv
// constants, tables and types for the date weekday and remaining days unit
`default_nettype none
package dwrd_pkg;

    localparam int unsigned DAY_W      = 5;
    localparam int unsigned MONTH_W    = 4;
    localparam int unsigned YEAR_W     = 14;
    localparam int unsigned YADJ_W     = 15;
    localparam int unsigned SUM_W      = 15;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 32;

    localparam logic [YADJ_W-1:0] YEAR_OFFSET = 15'd400;

    // quotient by 100: (x * RECIP_100) >> SHIFT_100, exact for x below 43690
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int unsigned SHIFT_100 = 19;
    localparam int unsigned PROD100_W = 27;
    localparam int unsigned Q100_W    = 8;

    // quotient by 7: (x * RECIP_7) >> SHIFT_7, exact for x below 43690
    localparam logic [15:0] RECIP_7 = 16'd37450;
    localparam int unsigned SHIFT_7 = 18;
    localparam int unsigned PROD7_W = 30;
    localparam int unsigned Q7_W    = 12;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [2:0] WD_FRIDAY   = 3'd5;
    localparam logic [2:0] WD_SATURDAY = 3'd6;

    typedef struct packed {
        logic [8:0] days_to_year_end;
        logic [4:0] days_to_month_end;
        logic [2:0] days_to_week_end;
        logic       business_day;
        logic       weekend;
        logic       end_of_week;
        logic [4:0] month_length;
        logic       leap_year;
        logic [2:0] weekday;
        logic       date_valid;
    } t_result;

    function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] month,
                                              input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:    len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // (31 * m) / 12 for shifted month 1..12
    function automatic logic [4:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [4:0] v;
        unique case (m)
            4'd1:    v = 5'd2;
            4'd2:    v = 5'd5;
            4'd3:    v = 5'd7;
            4'd4:    v = 5'd10;
            4'd5:    v = 5'd12;
            4'd6:    v = 5'd15;
            4'd7:    v = 5'd18;
            4'd8:    v = 5'd20;
            4'd9:    v = 5'd23;
            4'd10:   v = 5'd25;
            4'd11:   v = 5'd28;
            4'd12:   v = 5'd31;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

    // days in the months after this one, common year
    function automatic logic [8:0] days_after(input logic [MONTH_W-1:0] month);
        logic [8:0] v;
        unique case (month)
            4'd1:    v = 9'd334;
            4'd2:    v = 9'd306;
            4'd3:    v = 9'd275;
            4'd4:    v = 9'd245;
            4'd5:    v = 9'd214;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd153;
            4'd8:    v = 9'd122;
            4'd9:    v = 9'd92;
            4'd10:   v = 9'd61;
            4'd11:   v = 9'd31;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: design/date_weekday_and_remaining_days_unit.sv
// top level: weekday, leap year and remaining days for one date per beat
// an accepted input beat moves through registered stages 1 to 4 to become its output beat
// throughput: one beat per cycle while the output is not stalled, set by the four-stage pipeline
// a stalled output holds the whole pipeline, nothing is dropped
// reset: synchronous active low, clears every stage valid bit
`default_nettype none
module date_weekday_and_remaining_days_unit
    import dwrd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // day[4:0], month[8:5], year[22:9], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // date_valid[0], weekday[3:1], leap_year[4], month_length[9:5],
    // end_of_week[10], weekend[11], business_day[12], days_to_week_end[15:13],
    // days_to_month_end[20:16], days_to_year_end[29:21], zero pad
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    logic en;

    logic [DAY_W-1:0]   in_day;
    logic [MONTH_W-1:0] in_month;
    logic [YEAR_W-1:0]  in_year;
    logic               in_early;
    logic [YADJ_W-1:0]  n_yadj;
    logic [MONTH_W-1:0] n_madj;

    // stage 1
    logic                 r1_valid;
    logic [DAY_W-1:0]     r1_day;
    logic [MONTH_W-1:0]   r1_month;
    logic [YEAR_W-1:0]    r1_year;
    logic [YADJ_W-1:0]    r1_yadj;
    logic [MONTH_W-1:0]   r1_madj;
    logic [PROD100_W-1:0] r1_prod_y;
    logic [PROD100_W-1:0] r1_prod_year;

    // stage 2
    logic [Q100_W-1:0] q_y;
    logic [Q100_W-1:0] q_year;
    logic [YEAR_W-1:0] cent;
    logic              n_leap;
    logic [SUM_W-1:0]  n_sum;

    logic               r2_valid;
    logic [DAY_W-1:0]   r2_day;
    logic [MONTH_W-1:0] r2_month;
    logic               r2_leap;
    logic [SUM_W-1:0]   r2_sum;

    // stage 3
    logic [4:0] n_mlen;
    logic       n_ok;

    logic               r3_valid;
    logic               r3_ok;
    logic [DAY_W-1:0]   r3_day;
    logic [MONTH_W-1:0] r3_month;
    logic               r3_leap;
    logic [4:0]         r3_mlen;
    logic [SUM_W-1:0]   r3_sum;
    logic [PROD7_W-1:0] r3_prod7;

    // stage 4
    logic [Q7_W-1:0]  q7;
    logic [SUM_W-1:0] rem7;
    logic [2:0]       wd;
    logic             wknd;
    logic [4:0]       dtme;
    logic [8:0]       dtye;
    t_result          n_res;

    logic    r_out_valid;
    t_result r_res;

    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    assign in_day   = s_axis_tdata[DAY_W-1:0];
    assign in_month = s_axis_tdata[DAY_W+MONTH_W-1:DAY_W];
    assign in_year  = s_axis_tdata[DAY_W+MONTH_W+YEAR_W-1:DAY_W+MONTH_W];

    // january and february count as months 11 and 12 of the previous year
    always_comb begin
        in_early = (in_month <= MONTH_FEB);
        n_yadj   = {1'b0, in_year} + YEAR_OFFSET - {{(YADJ_W-1){1'b0}}, in_early};
        n_madj   = in_early ? (in_month + 4'd10) : (in_month - 4'd2);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_day       <= in_day;
            r1_month     <= in_month;
            r1_year      <= in_year;
            r1_yadj      <= n_yadj;
            r1_madj      <= n_madj;
            r1_prod_y    <= {{(PROD100_W-YADJ_W){1'b0}}, n_yadj}
                            * {{(PROD100_W-13){1'b0}}, RECIP_100};
            r1_prod_year <= {{(PROD100_W-YEAR_W){1'b0}}, in_year}
                            * {{(PROD100_W-13){1'b0}}, RECIP_100};
        end
    end

    always_comb begin
        q_y    = r1_prod_y[SHIFT_100+Q100_W-1:SHIFT_100];
        q_year = r1_prod_year[SHIFT_100+Q100_W-1:SHIFT_100];
        cent   = {{(YEAR_W-Q100_W){1'b0}}, q_year} * 14'd100;
        n_leap = (r1_year[1:0] == 2'b00) && ((r1_year != cent) || (q_year[1:0] == 2'b00));
        n_sum  = SUM_W'({10'd0, r1_day} + r1_yadj + (r1_yadj >> 2)
                 - {7'd0, q_y} + {9'd0, q_y[Q100_W-1:2]}
                 + {10'd0, month_offset(r1_madj)});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_day   <= r1_day;
            r2_month <= r1_month;
            r2_leap  <= n_leap;
            r2_sum   <= n_sum;
        end
    end

    always_comb begin
        n_mlen = month_days(r2_month, r2_leap);
        n_ok   = (n_mlen != 5'd0) && (r2_day != 5'd0) && (r2_day <= n_mlen);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_ok    <= n_ok;
            r3_day   <= r2_day;
            r3_month <= r2_month;
            r3_leap  <= r2_leap;
            r3_mlen  <= n_mlen;
            r3_sum   <= r2_sum;
            r3_prod7 <= {{(PROD7_W-SUM_W){1'b0}}, r2_sum} * {{(PROD7_W-16){1'b0}}, RECIP_7};
        end
    end

    always_comb begin
        q7    = r3_prod7[SHIFT_7+Q7_W-1:SHIFT_7];
        rem7  = r3_sum - ({{(SUM_W-Q7_W){1'b0}}, q7} * 15'd7);
        wd    = rem7[2:0];
        wknd  = (wd == WD_FRIDAY) || (wd == WD_SATURDAY);
        dtme  = r3_mlen - r3_day;
        dtye  = {4'd0, dtme} + days_after(r3_month)
              + {8'd0, (r3_leap && (r3_month == MONTH_JAN))};
        n_res = '0;
        if (r3_ok) begin
            n_res.date_valid        = 1'b1;
            n_res.weekday           = wd;
            n_res.leap_year         = r3_leap;
            n_res.month_length      = r3_mlen;
            n_res.end_of_week       = (wd == WD_SATURDAY);
            n_res.weekend           = wknd;
            n_res.business_day      = !wknd;
            n_res.days_to_week_end  = WD_SATURDAY - wd;
            n_res.days_to_month_end = dtme;
            n_res.days_to_year_end  = dtye;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= s_axis_tvalid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= r3_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W-$bits(t_result)){1'b0}}, r_res};

endmodule
`default_nettype wire

// File: design/dwrd_checker.sv
// port-level checker for the date weekday and remaining days unit
`default_nettype none
`include "date_weekday_and_remaining_days_unit_defines.svh"
module dwrd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    `DWRD_ASSERT_NEXT(a_reset_clears, i_clk, !i_rst_n, !m_axis_tvalid, "output valid after reset")

    `DWRD_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n && m_axis_tvalid && !m_axis_tready, !m_axis_tvalid || $stable(m_axis_tdata), "stalled beat changed")

    `DWRD_ASSERT_NOW(a_invalid_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[31:1] == 31'd0, "invalid date with nonzero fields")

    `DWRD_ASSERT_NOW(a_week_fields, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[0], (m_axis_tdata[3:1] != 3'd7) && (m_axis_tdata[15:13] == 3'd6 - m_axis_tdata[3:1]) && (m_axis_tdata[12] != m_axis_tdata[11]) && (m_axis_tdata[10] == (m_axis_tdata[3:1] == 3'd6)), "weekday fields disagree")

endmodule

bind date_weekday_and_remaining_days_unit dwrd_checker u_dwrd_checker (.*);
`default_nettype wire
